[src/mfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg: shared types and constants of the min-front deque
// Sizes, action and status codes, and ring pointer helpers.
// ----------------------------------------------------------------------------
package mfd_pkg;

   // Ring size and width of a stored value.
   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;

   // Fixed widths of the channel fields.
   localparam int ACTION_W = 2;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Internal widths that follow from the ring size.
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int SUM_W = PTR_W + 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH = 2'd0,
      ACT_POP  = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan_rd;
      logic mem_rd;
      logic finish;
   } mfd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic want_scan;
      logic want_read;
      logic scan_last;
      logic out_free;
   } mfd_stat_type;

   // Ring index that lies off entries past ptr.
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(ptr) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return PTR_W'(sum);
   endfunction

   // Ring index one before ptr.
   function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == '0) begin
         res = PTR_W'(DEPTH - 1);
      end else begin
         res = ptr - PTR_W'(1);
      end
      return res;
   endfunction

   function automatic logic pos_in_range(input logic [POS_W-1:0] pos,
                                         input logic [CNT_W-1:0] cnt);
      return CMP_W'(pos) < CMP_W'(cnt);
   endfunction

endpackage

[src/mfd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_ctrl: sequencer of the min-front deque
// Steps one request through scan, read and commit, and gates the request side.
// ----------------------------------------------------------------------------
module mfd_ctrl import mfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  mfd_stat_type stat,
   output mfd_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_READ  = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.capture = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (stat.want_scan) begin
                  state_in = ST_SCAN;
               end else if (stat.want_read) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // The last scanned entry is folded into the running minimum here.
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/mfd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_dp: datapath of the min-front deque
// Entry memory, ring pointers, minimum scan and the result register.
// ----------------------------------------------------------------------------
module mfd_dp import mfd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic signed [DATA_W-1:0]   req_value,
   input  logic [POS_W-1:0]           req_position,
   input  logic                       rsp_stall,
   input  mfd_cmd_type                cmd,
   output mfd_stat_type               stat,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_data,
   output logic                       rsp_went_front,
   output logic [COUNT_W-1:0]         rsp_count
);

   logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

   logic [ACTION_W-1:0]           op_ff;
   logic signed [VALUE_WIDTH-1:0] val_ff;
   logic [POS_W-1:0]              pos_ff;
   logic [PTR_W-1:0]              front_ff;
   logic [PTR_W-1:0]              front_in;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic [CNT_W-1:0]              idx_ff;
   logic signed [VALUE_WIDTH-1:0] min_ff;
   logic                          first_ff;
   logic                          scan_vld_ff;
   logic signed [VALUE_WIDTH-1:0] rdata_ff;

   logic                          rsp_valid_ff;
   logic [STATUS_W-1:0]           rsp_status_ff;
   logic signed [DATA_W-1:0]      rsp_data_ff;
   logic                          rsp_went_front_ff;
   logic [COUNT_W-1:0]            rsp_count_ff;

   logic                          empty;
   logic                          full;
   logic [PTR_W-1:0]              raddr;
   logic [PTR_W-1:0]              waddr;
   logic                          we;
   logic [STATUS_W-1:0]           res_status;
   logic signed [DATA_W-1:0]      res_data;
   logic                          res_went_front;

   assign empty = (count_ff == '0);
   assign full  = (count_ff >= CNT_W'(DEPTH));

   assign stat.want_scan = (req_action == ACT_PUSH) && !empty && !full;
   assign stat.want_read = ((req_action == ACT_POP) && !empty) ||
                           ((req_action == ACT_READ) &&
                            pos_in_range(req_position, count_ff));
   assign stat.scan_last = (idx_ff == (count_ff - CNT_W'(1)));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.scan_rd) begin
         raddr = wrap_add(front_ff, idx_ff);
      end else if (op_ff == ACT_POP) begin
         raddr = front_ff;
      end else begin
         raddr = wrap_add(front_ff, CNT_W'(pos_ff));
      end
   end

   // Outcome of the request, committed when the controller finishes it.
   always_comb begin
      res_status     = STAT_OK;
      res_data       = '0;
      res_went_front = 1'b0;
      we             = 1'b0;
      waddr          = front_ff;
      front_in       = front_ff;
      count_in       = count_ff;
      case (op_ff)
         ACT_PUSH: begin
            if (full) begin
               res_status = STAT_FULL;
            end else if (empty) begin
               we       = 1'b1;
               count_in = CNT_W'(1);
            end else if (val_ff < min_ff) begin
               we             = 1'b1;
               waddr          = wrap_dec(front_ff);
               front_in       = wrap_dec(front_ff);
               res_went_front = 1'b1;
               count_in       = count_ff + CNT_W'(1);
            end else begin
               we       = 1'b1;
               waddr    = wrap_add(front_ff, count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_POP: begin
            if (empty) begin
               res_status = STAT_EMPTY;
            end else begin
               res_data = DATA_W'(rdata_ff);
               count_in = count_ff - CNT_W'(1);
               // An emptied ring starts over at index zero.
               if (count_ff == CNT_W'(1)) begin
                  front_in = '0;
               end else begin
                  front_in = wrap_add(front_ff, CNT_W'(1));
               end
            end
         end
         ACT_READ: begin
            if (pos_in_range(pos_ff, count_ff)) begin
               res_data = DATA_W'(rdata_ff);
            end else begin
               res_status = STAT_EMPTY;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && we) begin
         mem[waddr] <= val_ff;
      end
      if (cmd.scan_rd || cmd.mem_rd) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_action;
         val_ff <= VALUE_WIDTH'(req_value);
         pos_ff <= req_position;
      end
      if (cmd.capture) begin
         first_ff <= 1'b1;
      end else if (scan_vld_ff) begin
         first_ff <= 1'b0;
      end
      if (scan_vld_ff && (first_ff || (rdata_ff < min_ff))) begin
         min_ff <= rdata_ff;
      end
      if (cmd.finish) begin
         rsp_status_ff     <= res_status;
         rsp_data_ff       <= res_data;
         rsp_went_front_ff <= res_went_front;
         rsp_count_ff      <= COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_vld_ff <= cmd.scan_rd;
         if (cmd.capture) begin
            idx_ff <= '0;
         end else if (cmd.scan_rd) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (cmd.finish) begin
            front_ff     <= front_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_went_front = rsp_went_front_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

[src/min_front_deque.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_front_deque: bounded ring deque that puts a new minimum at the front
// A push goes to the front when it is below every stored entry, else to the
// back; pop takes the front entry and read returns the entry at a position.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake           Fields
//   req_*     in          req_valid/stall     action, value, position
//   rsp_*     out         rsp_valid/stall     status, data, went_front, count
//
// A push into a deque holding n entries (1 <= n < DEPTH) reads all n entries
// through the single read port of the entry memory to find the minimum, folds
// in the last read and then commits. Pop and in-range read do one memory read
// and then commit; all other requests go straight to commit. Reset is
// synchronous and empties the deque; entry contents are not cleared. A
// stalled response holds the commit step, while a finished response waiting
// in the output register does not block the next request.
// ----------------------------------------------------------------------------
module min_front_deque import mfd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic [POS_W-1:0]          req_position,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [DATA_W-1:0]  rsp_data,
   output logic                      rsp_went_front,
   output logic [COUNT_W-1:0]        rsp_count
);

   mfd_cmd_type  cmd;
   mfd_stat_type stat;

   mfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mfd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_went_front (rsp_went_front),
      .rsp_count      (rsp_count)
   );

endmodule

[src/mfd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_checker: port-level checks of the min-front deque
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
module mfd_checker import mfd_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic signed [DATA_W-1:0]  rsp_data,
   input logic                      rsp_went_front,
   input logic [COUNT_W-1:0]        rsp_count
);

   // One request at a time: a transfer in closes the request side next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open right after a transfer");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |-> rsp_count == COUNT_W'(DEPTH))
      else $error("full status without a full deque");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> rsp_data == '0)
      else $error("data present on a failed request");

   a_front_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_went_front |->
         (rsp_status == STAT_OK) && (rsp_count >= COUNT_W'(2)))
      else $error("front placement without a prior entry");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data) &&
         $stable(rsp_count))
      else $error("stalled response changed");

endmodule

bind min_front_deque mfd_checker u_mfd_checker (.*);
